FILE: sv/multi_slot_countdown_timer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-slot countdown timer
// Concurrent checks clocked on clk; MST_ASSERT is held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_MACROS_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define MST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Codes, defaults and the slot entry type of the multi-slot countdown timer.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [1:0] KIND_CREATE  = 2'd0;
  localparam logic [1:0] KIND_DELETE  = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_SERVICE = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FAIL = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // One slot as stored in the entry memory.
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] reload;
    logic        periodic;
    logic        running;
    logic        notify;
  } entry_t;

endpackage

FILE: sv/multi_slot_countdown_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer
// Table of countdown timer slots kept in one entry memory, with create,
// delete, tick and service items and a registered result channel.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid / in_ready   | kind, slot, reload, periodic,
//          |           |                       | start_running, has_callback
//  out     | output    | out_valid / out_ready | status, slot_index, expired,
//          |           |                       | last
//  cfg     | input     | cfg_we                | cfg_wdata (tick_sync_enable)
//
//  Create and delete items give their result in the cycle after they are
//  accepted. Tick and service items walk the entry memory one slot per cycle,
//  reading slot i+1 while slot i is modified and written back; the memory
//  read is registered. A tick that is ignored under sync gives no item.
//  A stalled output holds the walk on the slot that has an event to report.
//  Synchronous reset frees all slots and clears service_seen; the entry
//  memory needs no clearing since slots not in use are never modified or
//  reported.

`include "multi_slot_countdown_timer_macros.svh"

module multi_slot_countdown_timer #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_slot,
  input  logic [31:0] in_reload,
  input  logic        in_periodic,
  input  logic        in_start_running,
  input  logic        in_has_callback,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [2:0]  out_slot_index,
  output logic        out_expired,
  output logic        out_last,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
  localparam int CW = $clog2(SLOTS + 1);                // walk counter width

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic                 state_r, state_nxt;
  logic                 svc_r, svc_nxt;          // pass is a service pass
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;    // next slot to read
  logic                 p_vld_r, p_vld_nxt;      // a slot sits in the modify stage
  logic [IW-1:0]        p_idx_r, p_idx_nxt;
  logic [SLOTS-1:0]     in_use_r, in_use_nxt;
  logic                 svc_seen_r, svc_seen_nxt;
  logic                 tick_sync_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [2:0]           out_slot_index_r, out_slot_index_nxt;
  logic                 out_expired_r, out_expired_nxt;
  logic                 out_last_r, out_last_nxt;

  // Entry memory: one write port, one registered read port.
  mst_pkg::entry_t      mem [SLOTS];
  mst_pkg::entry_t      rd_data_r;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  mst_pkg::entry_t      mem_wdata;
  logic                 rd_en;

  // --------------------------------------------------------------------------
  // Handshake and decode
  // --------------------------------------------------------------------------
  logic                 out_free;
  logic                 in_fire;
  logic                 free_hit;
  logic [IW-1:0]        free_idx;
  logic                 rd_more;
  logic                 p_use;
  logic                 hit_tick;
  logic                 hit_svc;
  logic                 emit;
  logic                 stall;
  logic                 adv;
  logic                 scan_end;
  logic                 del_bad;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign del_bad  = 7'(in_slot) >= 7'(SLOTS);

  // Lowest free slot.
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_hit = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign rd_more  = rd_idx_r != CW'(SLOTS);
  assign p_use    = in_use_r[p_idx_r];
  assign hit_tick = p_use && rd_data_r.running && (rd_data_r.count != 32'd0);
  assign hit_svc  = p_use && rd_data_r.running && (rd_data_r.count == 32'd0);
  assign emit     = p_vld_r && svc_r && hit_svc && rd_data_r.notify;
  // Hold the walk while an event waits for room in the output register.
  assign stall    = emit && !out_free;
  assign adv      = (state_r == ST_SCAN) && !stall;
  assign rd_en    = adv && rd_more;
  assign scan_end = (state_r == ST_SCAN) && !p_vld_r && !rd_more;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt          = state_r;
    svc_nxt            = svc_r;
    rd_idx_nxt         = rd_idx_r;
    p_vld_nxt          = p_vld_r;
    p_idx_nxt          = p_idx_r;
    in_use_nxt         = in_use_r;
    svc_seen_nxt       = svc_seen_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_status_nxt     = out_status_r;
    out_slot_index_nxt = out_slot_index_r;
    out_expired_nxt    = out_expired_r;
    out_last_nxt       = out_last_r;
    mem_we             = 1'b0;
    mem_waddr          = p_idx_r;
    mem_wdata          = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            mst_pkg::KIND_CREATE: begin
              out_valid_nxt      = 1'b1;
              out_expired_nxt    = 1'b0;
              out_last_nxt       = 1'b1;
              out_slot_index_nxt = 3'd0;
              if (in_reload == 32'd0) begin
                out_status_nxt = mst_pkg::STATUS_FAIL;
              end else if (!free_hit) begin
                out_status_nxt = mst_pkg::STATUS_FULL;
              end else begin
                // Claim the slot and store its whole entry.
                out_status_nxt       = mst_pkg::STATUS_OK;
                out_slot_index_nxt   = 3'(free_idx);
                in_use_nxt[free_idx] = 1'b1;
                mem_we               = 1'b1;
                mem_waddr            = free_idx;
                mem_wdata.count      = in_reload;
                mem_wdata.reload     = in_reload;
                mem_wdata.periodic   = in_periodic;
                mem_wdata.running    = in_start_running;
                mem_wdata.notify     = in_has_callback;
              end
            end
            mst_pkg::KIND_DELETE: begin
              out_valid_nxt      = 1'b1;
              out_expired_nxt    = 1'b0;
              out_last_nxt       = 1'b1;
              out_slot_index_nxt = in_slot;
              if (del_bad) begin
                out_status_nxt = mst_pkg::STATUS_FAIL;
              end else begin
                out_status_nxt           = mst_pkg::STATUS_OK;
                in_use_nxt[IW'(in_slot)] = 1'b0;
              end
            end
            mst_pkg::KIND_TICK: begin
              // Drop the tick when sync is on and no service pass ran.
              if (!tick_sync_r || svc_seen_r) begin
                svc_seen_nxt = 1'b0;
                svc_nxt      = 1'b0;
                rd_idx_nxt   = '0;
                p_vld_nxt    = 1'b0;
                state_nxt    = ST_SCAN;
              end
            end
            default: begin
              svc_seen_nxt = 1'b1;
              svc_nxt      = 1'b1;
              rd_idx_nxt   = '0;
              p_vld_nxt    = 1'b0;
              state_nxt    = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (adv) begin
          // Modify and write back the slot in the modify stage.
          if (p_vld_r) begin
            if (svc_r) begin
              if (hit_svc) begin
                mem_we = 1'b1;
                if (rd_data_r.periodic) begin
                  mem_wdata.count = rd_data_r.reload;
                end else begin
                  mem_wdata.running = 1'b0;
                end
              end
            end else if (hit_tick) begin
              mem_we          = 1'b1;
              mem_wdata.count = rd_data_r.count - 32'd1;
            end
          end
          if (emit) begin
            out_valid_nxt      = 1'b1;
            out_status_nxt     = mst_pkg::STATUS_OK;
            out_slot_index_nxt = 3'(p_idx_r);
            out_expired_nxt    = 1'b1;
            out_last_nxt       = 1'b0;
          end
          // Advance the read side.
          p_vld_nxt = rd_more;
          if (rd_more) begin
            p_idx_nxt  = rd_idx_r[IW-1:0];
            rd_idx_nxt = rd_idx_r + CW'(1);
          end
        end
        if (scan_end) begin
          if (!svc_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            // Final item of the service pass.
            out_valid_nxt      = 1'b1;
            out_status_nxt     = mst_pkg::STATUS_OK;
            out_slot_index_nxt = 3'd0;
            out_expired_nxt    = 1'b0;
            out_last_nxt       = 1'b1;
            state_nxt          = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_vld_r     <= 1'b0;
      in_use_r    <= '0;
      svc_seen_r  <= 1'b0;
      tick_sync_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_vld_r     <= p_vld_nxt;
      in_use_r    <= in_use_nxt;
      svc_seen_r  <= svc_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tick_sync_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    svc_r            <= svc_nxt;
    rd_idx_r         <= rd_idx_nxt;
    p_idx_r          <= p_idx_nxt;
    out_status_r     <= out_status_nxt;
    out_slot_index_r <= out_slot_index_nxt;
    out_expired_r    <= out_expired_nxt;
    out_last_r       <= out_last_nxt;
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IW-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_index_r;
  assign out_expired    = out_expired_r;
  assign out_last       = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MST_ASSERT(a_scan_write_staged, (state_r == ST_SCAN && mem_we) |-> p_vld_r, "scan write without a staged slot")
  `MST_ASSERT(a_stall_holds_slot, (p_vld_r && stall) |=> (p_vld_r && $stable(p_idx_r)), "stalled slot moved")
  `MST_ASSERT(a_final_item, (scan_end && svc_r && out_free) |=> (out_valid && out_last && !out_expired), "service pass ended without final item")
  `MST_ASSERT_ALWAYS(a_no_accept_in_scan, (state_r == ST_SCAN) |-> !in_ready, "item accepted during a pass")

endmodule

FILE: tb/sv/multi_slot_countdown_timer_test.sv
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_test
// Self-checking bench for the timer slot table. A shadow table predicts the
// result items of every accepted create, delete, tick and service item; a
// sink process compares each result in order. Both channels idle at random,
// and one stretch holds the result side off so the block backs up.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = mst_pkg::SLOTS_DEF;
  localparam int MAX_GAP   = 18;
  // Pad for a tick or service walk when idling out.
  localparam int WALK_PAD  = SLOTS + 6;
  localparam int HOLD_OFF  = 400;
  localparam int CYCLE_CAP = 400000;

  // One input item as the bench builds it.
  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [31:0] reload;
    logic        periodic;
    logic        start_running;
    logic        has_callback;
  } timer_cmd_t;

  // One result item as predicted.
  typedef struct {
    logic [1:0] status;
    logic [2:0] slot_index;
    logic       expired;
    logic       last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = mst_pkg::KIND_TICK;
  logic [2:0]  in_slot = '0;
  logic [31:0] in_reload = '0;
  logic        in_periodic = 1'b0;
  logic        in_start_running = 1'b0;
  logic        in_has_callback = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_slot_index;
  logic        out_expired;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  // Shadow copy of the slot table and the sync register.
  bit          shadow_in_use [SLOTS];
  bit [31:0]   shadow_count  [SLOTS];
  bit [31:0]   shadow_reload [SLOTS];
  bit          shadow_periodic [SLOTS];
  bit          shadow_running  [SLOTS];
  bit          shadow_notify   [SLOTS];
  bit          shadow_service_seen = 1'b0;
  bit          shadow_sync_en = 1'b1;

  timer_result_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;

  // Idling controls: burst drops the random gaps, hold parks the sink.
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  logic        rx_hold = 1'b0;

  multi_slot_countdown_timer #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_reload        (in_reload),
    .in_periodic      (in_periodic),
    .in_start_running (in_start_running),
    .in_has_callback  (in_has_callback),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_expired      (out_expired),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("** multi_slot_countdown_timer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow table
  // --------------------------------------------------------------------------
  function automatic void queue_result(logic [1:0] status, logic [2:0] idx,
                                       logic expired, logic last);
    timer_result_t r;
    r.status     = status;
    r.slot_index = idx;
    r.expired    = expired;
    r.last       = last;
    pending_results.push_back(r);
  endfunction

  // Advance the shadow table by one accepted item and queue its results.
  function automatic void advance_timer_table(timer_cmd_t c);
    int  i;
    bit  placed;
    placed = 1'b0;
    if (c.kind == mst_pkg::KIND_CREATE) begin
      if (c.reload == 32'd0) begin
        queue_result(mst_pkg::STATUS_FAIL, 3'd0, 1'b0, 1'b1);
      end else begin
        for (i = 0; i < SLOTS; i++) begin
          if (!placed && !shadow_in_use[i]) begin
            placed             = 1'b1;
            shadow_in_use[i]   = 1'b1;
            shadow_reload[i]   = c.reload;
            shadow_count[i]    = c.reload;
            shadow_periodic[i] = c.periodic;
            shadow_running[i]  = c.start_running;
            shadow_notify[i]   = c.has_callback;
            queue_result(mst_pkg::STATUS_OK, i[2:0], 1'b0, 1'b1);
          end
        end
        if (!placed) queue_result(mst_pkg::STATUS_FULL, 3'd0, 1'b0, 1'b1);
      end
    end else if (c.kind == mst_pkg::KIND_DELETE) begin
      if (int'(c.slot) >= SLOTS) begin
        queue_result(mst_pkg::STATUS_FAIL, c.slot, 1'b0, 1'b1);
      end else begin
        shadow_in_use[c.slot] = 1'b0;
        queue_result(mst_pkg::STATUS_OK, c.slot, 1'b0, 1'b1);
      end
    end else if (c.kind == mst_pkg::KIND_TICK) begin
      // Under sync, a tick counts only once a service pass has run.
      if (!(shadow_sync_en && !shadow_service_seen)) begin
        shadow_service_seen = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
          if (shadow_in_use[i] && shadow_running[i] && shadow_count[i] != 0)
            shadow_count[i] = shadow_count[i] - 1;
        end
      end
    end else begin
      shadow_service_seen = 1'b1;
      for (i = 0; i < SLOTS; i++) begin
        if (shadow_in_use[i] && shadow_running[i] && shadow_count[i] == 0) begin
          if (shadow_notify[i]) queue_result(mst_pkg::STATUS_OK, i[2:0], 1'b1, 1'b0);
          if (shadow_periodic[i]) shadow_count[i] = shadow_reload[i];
          else shadow_running[i] = 1'b0;
        end
      end
      queue_result(mst_pkg::STATUS_OK, 3'd0, 1'b0, 1'b1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Item builders: fields the kind ignores carry random noise
  // --------------------------------------------------------------------------
  function automatic timer_cmd_t noise_cmd(logic [1:0] kind);
    timer_cmd_t c;
    c.kind          = kind;
    c.slot          = 3'($urandom_range(0, 7));
    c.reload        = $urandom();
    c.periodic      = 1'($urandom_range(0, 1));
    c.start_running = 1'($urandom_range(0, 1));
    c.has_callback  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic timer_cmd_t create_cmd(logic [31:0] reload, logic periodic,
                                            logic running, logic notify);
    timer_cmd_t c;
    c               = noise_cmd(mst_pkg::KIND_CREATE);
    c.reload        = reload;
    c.periodic      = periodic;
    c.start_running = running;
    c.has_callback  = notify;
    return c;
  endfunction

  function automatic timer_cmd_t delete_cmd(logic [2:0] slot);
    timer_cmd_t c;
    c      = noise_cmd(mst_pkg::KIND_DELETE);
    c.slot = slot;
    return c;
  endfunction

  // Mostly short timeouts so slots expire; now and then zero or a huge one.
  function automatic logic [31:0] pick_reload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 32'd0;
    if (r < 75) return 32'($urandom_range(1, 4));
    if (r < 90) return 32'($urandom_range(5, 12));
    return $urandom();
  endfunction

  // Prefer a slot in use so deletes actually free something.
  function automatic logic [2:0] pick_delete_slot();
    int start;
    int k;
    start = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 3) != 0) begin
      for (k = 0; k < SLOTS; k++) begin
        if (shadow_in_use[(start + k) % SLOTS]) return 3'((start + k) % SLOTS);
      end
    end
    return 3'(start);
  endfunction

  // --------------------------------------------------------------------------
  // Sender and configuration
  // --------------------------------------------------------------------------
  // Offer one item after a random gap, hold it until taken, then predict it.
  task automatic send_cmd(input timer_cmd_t c);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= c.kind;
    in_slot          <= c.slot;
    in_reload        <= c.reload;
    in_periodic      <= c.periodic;
    in_start_running <= c.start_running;
    in_has_callback  <= c.has_callback;
    do @(posedge clk); while (!in_ready);
    advance_timer_table(c);
  endtask

  // Drop valid and wait until every result is in and any tick walk is over.
  task automatic wait_block_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (WALK_PAD) @(posedge clk);
  endtask

  task automatic write_tick_sync(input bit value);
    wait_block_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_sync_en = value;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, long hold when asked, in-order compare
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_sink
    timer_result_t want;
    int unsigned   stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result item with none expected: status %0d slot %0d expired %0d last %0d",
               out_status, out_slot_index, out_expired, out_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("slot_index", 32'(want.slot_index), 32'(out_slot_index));
        check_field("expired", 32'(want.expired), 32'(out_expired));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Zero reload, both reload extremes, silent and stopped slots.
  task automatic test_create_modes();
    send_cmd(create_cmd(32'd0, 1'b1, 1'b1, 1'b1));
    send_cmd(create_cmd(32'd1, 1'b1, 1'b1, 1'b1));
    send_cmd(create_cmd(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
    send_cmd(create_cmd(32'd2, 1'b0, 1'b1, 1'b0));
    send_cmd(create_cmd(32'd1, 1'b1, 1'b0, 1'b1));
  endtask

  // Sync on: a tick without a service pass before it is dropped; periodic
  // reload, one-shot stop, silent expiry.
  task automatic test_expiry_under_sync();
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
  endtask

  // Fill the table, overflow it, then free slots, one of them twice.
  task automatic test_table_full();
    int k;
    for (k = 0; k < 4; k++)
      send_cmd(create_cmd(32'd3, 1'($urandom_range(0, 1)), 1'b1, 1'b1));
    send_cmd(create_cmd(32'd5, 1'b1, 1'b1, 1'b1));
    send_cmd(delete_cmd(3'd1));
    send_cmd(delete_cmd(3'd7));
    send_cmd(delete_cmd(3'd7));
  endtask

  // Sync off: back-to-back ticks all count and the count sticks at zero.
  task automatic test_free_running_ticks();
    write_tick_sync(1'b0);
    send_cmd(create_cmd(32'd1, 1'b0, 1'b1, 1'b1));
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_TICK));
    send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
  endtask

  // Mostly tick/service pairs among creates and deletes, some stray items.
  task automatic test_random_traffic(input bit sync_value, input int n_items);
    int          sent;
    int unsigned r;
    write_tick_sync(sync_value);
    sent = 0;
    while (sent < n_items) begin
      // Run a stretch of the phase with no idling on either side.
      tx_burst = (sent >= n_items / 3) && (sent < n_items / 2);
      rx_burst = tx_burst;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_cmd(create_cmd(pick_reload(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 7) != 0), 1'($urandom_range(0, 5) != 0)));
        sent++;
      end else if (r < 40) begin
        send_cmd(delete_cmd(pick_delete_slot()));
        sent++;
      end else if (r < 75) begin
        send_cmd(noise_cmd(mst_pkg::KIND_TICK));
        send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
        sent += 2;
      end else if (r < 88) begin
        send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
        sent++;
      end else begin
        send_cmd(noise_cmd(mst_pkg::KIND_TICK));
        sent++;
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Park the sink for a long stretch while items keep coming in, so the
  // block backs up and drops in_ready.
  task automatic test_output_backpressure();
    int k;
    rx_hold  <= 1'b1;
    tx_burst = 1'b1;
    fork
      begin
        repeat (HOLD_OFF) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (k = 0; k < 20; k++) begin
      if (k % 4 == 0) send_cmd(create_cmd(pick_reload(), 1'b1, 1'b1, 1'b1));
      else if (k % 4 == 1) send_cmd(noise_cmd(mst_pkg::KIND_TICK));
      else send_cmd(noise_cmd(mst_pkg::KIND_SERVICE));
    end
    tx_burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_create_modes();
    test_expiry_under_sync();
    test_table_full();
    test_free_running_ticks();
    test_random_traffic(1'b1, 50);
    test_random_traffic(1'b0, 50);
    write_tick_sync(1'b1);
    test_output_backpressure();
    test_random_traffic(1'b1, 30);

    // Drain: wait out the last results and any walk still in flight.
    wait_block_idle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** multi_slot_countdown_timer: PASSED **");
    end else begin
      $display("** multi_slot_countdown_timer: FAILED **");
    end
    $finish;
  end

endmodule
